// ----- rtl/pll_divider_solver_macros.svh -----
// -----------------------------------------------------------------------------
// pll_divider_solver_macros.svh
// Assertion helpers shared by the solver modules.
// -----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SOLVER_MACROS_SVH
`define PLL_DIVIDER_SOLVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pll_divider_solver: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pll_divider_solver: assertion failed");

`endif

// ----- rtl/pds_pkg.sv -----
// -----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the PLL divider solver.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pds_pkg;

  // Field widths
  localparam int FreqW  = 28;
  localparam int RefDivW = 14;
  localparam int CbW    = 13;
  localparam int CaW    = 5;
  localparam int PcbW   = 19;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 3;

  // Band limits in Hz
  localparam logic [31:0] BAND_LOW_HZ  = 32'd2550000000;
  localparam logic [31:0] BAND_HIGH_HZ = 32'd2950000000;
  localparam logic [CbW-1:0] B_MAX     = 13'd8191;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_VCO_TARGET  = 3'd0,
    REG_REF_FREQ    = 3'd1,
    REG_MAX_DIFF    = 3'd2,
    REG_REF_DIVIDER = 3'd3,
    REG_PRESCALER   = 3'd4,
    REG_DEFAULT_B   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [31:0]        vco_target;
    logic [31:0]        ref_freq;
    logic [26:0]        max_diff;
    logic [RefDivW-1:0] ref_divider;
    logic [5:0]         prescaler;
    logic [CbW-1:0]     default_b;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_ERR,
    OP_XMUL,
    OP_UPD,
    OP_MATCH,
    OP_NPROD,
    OP_NMUL,
    OP_DIVN,
    OP_TAKEN,
    OP_DIVP,
    OP_TAKEQ,
    OP_FB1,
    OP_FB2,
    OP_FB3
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic last;
    logic div_done;
  } status_t;

endpackage

// ----- rtl/pll_divider_solver.sv -----
// -----------------------------------------------------------------------------
// pll_divider_solver
// Searches PLL output dividers for a requested frequency and derives B/A.
// -----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The search visits
// every VCO/first/second divider combination in loop order (2640 with the
// default limits), each through product, error, cross-multiply and compare;
// an early match ends it sooner. Without a match, two bit-serial divisions
// (N, then B and A) plus setup and band check follow. The result shows
// on the output ports for exactly one cycle with valid_o high and cannot be
// held off; a new request may be started while it shows.
`timescale 1ns / 1ps
module pll_divider_solver #(
  parameter int VCO_DIV_MAX = 6,
  parameter int OUT_DIV_MAX = 32,
  localparam int VW = $clog2(VCO_DIV_MAX + 1),
  localparam int OW = $clog2(OUT_DIV_MAX + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [pds_pkg::FreqW-1:0]    target_freq_i,
  input  logic                         cfg_we_i,
  input  logic [pds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pds_pkg::CfgW-1:0]     cfg_data_i,
  output logic                         valid_o,
  output logic [VW-1:0]                vco_divider_o,
  output logic [OW-1:0]                first_divider_o,
  output logic [OW-1:0]                second_divider_o,
  output logic [pds_pkg::CbW-1:0]      counter_b_o,
  output logic [pds_pkg::CaW-1:0]      counter_a_o,
  output logic                         matched_o,
  output logic                         vco_out_of_range_o
);
  import pds_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vco_target  <= 32'd2800000000;
      cfg_q.ref_freq    <= 32'd40000000;
      cfg_q.max_diff    <= '0;
      cfg_q.ref_divider <= RefDivW'(1000);
      cfg_q.prescaler   <= 6'd16;
      cfg_q.default_b   <= CbW'(4375);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VCO_TARGET:  cfg_q.vco_target  <= cfg_data_i;
        REG_REF_FREQ:    cfg_q.ref_freq    <= cfg_data_i;
        REG_MAX_DIFF:    cfg_q.max_diff    <= cfg_data_i[26:0];
        REG_REF_DIVIDER: cfg_q.ref_divider <= cfg_data_i[RefDivW-1:0];
        REG_PRESCALER:   cfg_q.prescaler   <= cfg_data_i[5:0];
        REG_DEFAULT_B:   cfg_q.default_b   <= cfg_data_i[CbW-1:0];
        default: ;
      endcase
    end
  end

  pds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  pds_dp #(
    .VCO_DIV_MAX (VCO_DIV_MAX),
    .OUT_DIV_MAX (OUT_DIV_MAX),
    .VW          (VW),
    .OW          (OW)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg_q),
    .target_freq_i      (target_freq_i),
    .status_o           (status),
    .vco_divider_o      (vco_divider_o),
    .first_divider_o    (first_divider_o),
    .second_divider_o   (second_divider_o),
    .counter_b_o        (counter_b_o),
    .counter_a_o        (counter_a_o),
    .matched_o          (matched_o),
    .vco_out_of_range_o (vco_out_of_range_o),
    .valid_o            (valid_o)
  );
endmodule

// ----- rtl/pds_div.sv -----
// -----------------------------------------------------------------------------
// pds_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pll_divider_solver_macros.svh"
module pds_div #(
  parameter int DW = 55
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [31:0]   divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic [31:0]   remainder_o,
  output logic          done_o
);
  localparam int CntW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q;
  logic [32:0]     rem_q;
  logic [31:0]     dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [32:0]     shifted, diff;
  logic            fits;

  // Trial subtraction of the shifted partial remainder
  always_comb begin
    shifted = {rem_q[31:0], quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff : shifted;
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[31:0];
  assign done_o      = done_q;

  `PDS_ASSERT_NEXT(a_busy_ends_done, clk_i, rst_ni, busy_q && !start_i, busy_q || done_q)
  `PDS_ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q)
  `PDS_ASSERT_IMPL(a_cnt_nonzero, clk_i, rst_ni, busy_q, cnt_q != '0)
endmodule

// ----- rtl/pds_ctrl.sv -----
// -----------------------------------------------------------------------------
// pds_ctrl
// Sequencer of the divider search and the counter computation.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pll_divider_solver_macros.svh"
module pds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pds_pkg::status_t status_i,
  output pds_pkg::cmd_t    cmd_o
);
  import pds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ERR, S_XMUL, S_CMP, S_NPROD, S_NMUL, S_DIVN,
    S_WAITN, S_DIVP, S_WAITP, S_FB1, S_FB2, S_FB3
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  op_e    op;

  // Pick next state and datapath operation
  always_comb begin
    state_d = state_q;
    op      = OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op      = OP_LOAD;
          state_d = S_MUL;
        end
      end
      S_MUL:  begin op = OP_MUL;  state_d = S_ERR;  end
      S_ERR:  begin op = OP_ERR;  state_d = S_XMUL; end
      S_XMUL: begin op = OP_XMUL; state_d = S_CMP;  end
      S_CMP: begin
        if (status_i.match) begin
          op      = OP_MATCH;
          state_d = S_FB1;
        end else begin
          op      = OP_UPD;
          state_d = status_i.last ? S_NPROD : S_MUL;
        end
      end
      S_NPROD: begin op = OP_NPROD; state_d = S_NMUL; end
      S_NMUL:  begin op = OP_NMUL;  state_d = S_DIVN; end
      S_DIVN:  begin op = OP_DIVN;  state_d = S_WAITN; end
      S_WAITN: begin
        if (status_i.div_done) begin
          op      = OP_TAKEN;
          state_d = S_DIVP;
        end
      end
      S_DIVP:  begin op = OP_DIVP;  state_d = S_WAITP; end
      S_WAITP: begin
        if (status_i.div_done) begin
          op      = OP_TAKEQ;
          state_d = S_FB1;
        end
      end
      S_FB1: begin op = OP_FB1; state_d = S_FB2; end
      S_FB2: begin op = OP_FB2; state_d = S_FB3; end
      S_FB3: begin op = OP_FB3; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy      = busy_q;
  assign cmd_o.op  = op;

  `PDS_ASSERT_IMPL(a_busy_tracks_state, clk_i, rst_ni, 1'b1, busy_q == (state_q != S_IDLE))
  `PDS_ASSERT_NEXT(a_start_goes_busy, clk_i, rst_ni, start && !busy_q, busy_q)
  `PDS_ASSERT_NEXT(a_match_ends_search, clk_i, rst_ni, state_q == S_CMP && status_i.match,
                   state_q == S_FB1)
endmodule

// ----- rtl/pds_dp.sv -----
// -----------------------------------------------------------------------------
// pds_dp
// Datapath: combination error test, best tracking, N and counter math.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pll_divider_solver_macros.svh"
module pds_dp #(
  parameter int VCO_DIV_MAX = 6,
  parameter int OUT_DIV_MAX = 32,
  parameter int VW = 3,
  parameter int OW = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pds_pkg::cmd_t            cmd_i,
  input  pds_pkg::cfg_t            cfg_i,
  input  logic [pds_pkg::FreqW-1:0] target_freq_i,
  output pds_pkg::status_t         status_o,
  output logic [VW-1:0]            vco_divider_o,
  output logic [OW-1:0]            first_divider_o,
  output logic [OW-1:0]            second_divider_o,
  output logic [pds_pkg::CbW-1:0]  counter_b_o,
  output logic [pds_pkg::CaW-1:0]  counter_a_o,
  output logic                     matched_o,
  output logic                     vco_out_of_range_o,
  output logic                     valid_o
);
  import pds_pkg::*;

  localparam int IjW = $clog2(VCO_DIV_MAX * OUT_DIV_MAX + 1);
  localparam int PW  = $clog2(VCO_DIV_MAX * OUT_DIV_MAX * OUT_DIV_MAX + 1);
  localparam int FpW = FreqW + PW;
  localparam int EW  = (FpW > 32) ? FpW : 32;
  localparam int MdW = 27 + PW;
  localparam int XW  = EW + PW;
  localparam int NW  = FpW + RefDivW;
  localparam int FvW = 32 + PcbW;
  localparam int BwW = 32 + RefDivW;

  // Search indices and products
  logic [VW-1:0]  i_q, i_d;
  logic [OW-1:0]  j_q, j_d, k_q, k_d;
  logic [IjW-1:0] ij_q, ij_d;
  logic [PW-1:0]  prod_q;
  logic [FreqW-1:0] freq_q;
  logic [FpW-1:0] fp_q;
  logic [MdW-1:0] mdp_q;
  logic [EW-1:0]  err_q, err_w, berr_q;
  logic           match_q, have_q, better;
  logic [XW-1:0]  lhs_q, rhs_q;
  logic [PW-1:0]  bprod_q;
  logic [VW-1:0]  bv_q;
  logic [OW-1:0]  b1_q, b2_q;
  logic           matched_q;
  // Counter computation
  logic [FpW-1:0] t_q;
  logic [NW-1:0]  num_q, n_q;
  logic [CbW-1:0] cb_q;
  logic [CaW-1:0] ca_q;
  logic [PcbW-1:0] pcb_q;
  logic [FvW-1:0] fv_q;
  logic [BwW-1:0] lo_q, hi_q;
  // Effective configuration
  logic [5:0]         p_w;
  logic [RefDivW-1:0] r_w;
  logic [31:0]        fref_w;
  // Divider hookup
  logic           div_start;
  logic [NW-1:0]  div_dividend, div_quo;
  logic [31:0]    div_divisor, div_rem;
  logic           div_done;
  // Output registers
  logic [VW-1:0]  out_v_q;
  logic [OW-1:0]  out_1_q, out_2_q;
  logic [CbW-1:0] out_b_q;
  logic [CaW-1:0] out_a_q;
  logic           out_m_q, out_oor_q, valid_q;

  // Clamp the configuration to usable values
  always_comb begin
    p_w    = (cfg_i.prescaler == 6'd0) ? 6'd1 :
             (cfg_i.prescaler > 6'd32) ? 6'd32 : cfg_i.prescaler;
    r_w    = (cfg_i.ref_divider == '0) ? RefDivW'(1) : cfg_i.ref_divider;
    fref_w = (cfg_i.ref_freq == '0) ? 32'd1 : cfg_i.ref_freq;
  end

  // Error of the current combination and tie-breaking compare
  always_comb begin
    err_w  = (EW'(cfg_i.vco_target) >= EW'(fp_q)) ? EW'(cfg_i.vco_target) - EW'(fp_q)
                                                   : EW'(fp_q) - EW'(cfg_i.vco_target);
    better = !have_q || (lhs_q < rhs_q);
  end

  // Advance k, then j, then i in loop order
  always_comb begin
    i_d  = i_q;
    j_d  = j_q;
    k_d  = k_q;
    ij_d = ij_q;
    if (k_q == OW'(OUT_DIV_MAX)) begin
      if (j_q == OW'(OUT_DIV_MAX)) begin
        i_d  = i_q + 1'b1;
        j_d  = OW'(1);
        k_d  = OW'(1);
        ij_d = IjW'(i_q + 1'b1);
      end else begin
        j_d  = j_q + 1'b1;
        k_d  = j_q + 1'b1;
        ij_d = ij_q + IjW'(i_q);
      end
    end else begin
      k_d = k_q + 1'b1;
    end
  end

  // Divider operand select
  always_comb begin
    div_start    = (cmd_i.op == OP_DIVN) || (cmd_i.op == OP_DIVP);
    div_dividend = (cmd_i.op == OP_DIVN) ? num_q : n_q;
    div_divisor  = (cmd_i.op == OP_DIVN) ? fref_w : {26'd0, p_w};
  end

  pds_div #(.DW(NW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      matched_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= (cmd_i.op == OP_FB3);
      if (cmd_i.op == OP_LOAD) begin
        have_q    <= 1'b0;
        matched_q <= 1'b0;
      end else if (cmd_i.op == OP_UPD && better) begin
        have_q <= 1'b1;
      end else if (cmd_i.op == OP_MATCH) begin
        matched_q <= 1'b1;
      end
    end
  end

  // Payload registers, one operation per cycle
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        freq_q <= target_freq_i;
        i_q    <= VW'(2);
        j_q    <= OW'(1);
        k_q    <= OW'(1);
        ij_q   <= IjW'(2);
        prod_q <= PW'(2);
      end
      OP_MUL: begin
        fp_q  <= FpW'(freq_q * prod_q);
        mdp_q <= MdW'(cfg_i.max_diff * prod_q);
      end
      OP_ERR: begin
        err_q   <= err_w;
        match_q <= (err_w <= EW'(mdp_q));
      end
      OP_XMUL: begin
        lhs_q <= XW'(err_q * bprod_q);
        rhs_q <= XW'(berr_q * prod_q);
      end
      OP_UPD: begin
        if (better) begin
          berr_q  <= err_q;
          bprod_q <= prod_q;
          bv_q    <= i_q;
          b1_q    <= j_q;
          b2_q    <= k_q;
        end
        i_q    <= i_d;
        j_q    <= j_d;
        k_q    <= k_d;
        ij_q   <= ij_d;
        prod_q <= PW'(ij_d * k_d);
      end
      OP_MATCH: begin
        bv_q <= i_q;
        b1_q <= j_q;
        b2_q <= k_q;
        cb_q <= cfg_i.default_b;
        ca_q <= '0;
      end
      OP_NPROD: t_q   <= FpW'(bprod_q * freq_q);
      OP_NMUL:  num_q <= NW'(t_q * r_w);
      OP_TAKEN: n_q   <= div_quo;
      OP_TAKEQ: begin
        cb_q <= (div_quo > NW'(B_MAX)) ? B_MAX : div_quo[CbW-1:0];
        ca_q <= div_rem[CaW-1:0];
      end
      OP_FB1: pcb_q <= PcbW'(p_w * cb_q) + PcbW'(ca_q);
      OP_FB2: begin
        fv_q <= FvW'(cfg_i.ref_freq * pcb_q);
        lo_q <= BwW'(BAND_LOW_HZ * r_w);
        hi_q <= BwW'(BAND_HIGH_HZ * r_w);
      end
      OP_FB3: begin
        out_v_q   <= bv_q;
        out_1_q   <= b1_q;
        out_2_q   <= b2_q;
        out_b_q   <= cb_q;
        out_a_q   <= ca_q;
        out_m_q   <= matched_q;
        out_oor_q <= (fv_q < FvW'(lo_q)) || (fv_q > FvW'(hi_q));
      end
      OP_NOP, OP_DIVN, OP_DIVP: ;
      default: ;
    endcase
  end

  assign status_o.match    = match_q;
  assign status_o.last     = (i_q == VW'(VCO_DIV_MAX)) && (j_q == OW'(OUT_DIV_MAX)) &&
                             (k_q == OW'(OUT_DIV_MAX));
  assign status_o.div_done = div_done;

  assign vco_divider_o      = out_v_q;
  assign first_divider_o    = out_1_q;
  assign second_divider_o   = out_2_q;
  assign counter_b_o        = out_b_q;
  assign counter_a_o        = out_a_q;
  assign matched_o          = out_m_q;
  assign vco_out_of_range_o = out_oor_q;
  assign valid_o            = valid_q;

  `PDS_ASSERT_NEXT(a_valid_single, clk_i, rst_ni, valid_q, !valid_q)
  `PDS_ASSERT_NEXT(a_upd_sets_have, clk_i, rst_ni, cmd_i.op == OP_UPD, have_q)
  `PDS_ASSERT_IMPL(a_k_not_below_j, clk_i, rst_ni, cmd_i.op == OP_MUL, k_q >= j_q)
endmodule
